### src/key_value_table_macros.svh
// assertion macros for the key value table
`ifndef KEY_VALUE_TABLE_MACROS_SVH
`define KEY_VALUE_TABLE_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define KVT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("key_value_table assertion failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define KVT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key_value_table assertion failed");

`endif

### src/kvt_pkg.sv
// shared types and constants of the key value table
`default_nettype none

package kvt_pkg;

    // table size default and fixed field widths
    localparam int DEF_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int COUNT_W     = 5;

    // operation codes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    // request transaction
    typedef struct packed {
        logic [1:0]              mode;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_req;

    // result transaction
    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] value_out;
        logic [COUNT_W-1:0]      entry_count;
        logic                    table_full;
    } t_rsp;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic clear;
        logic scan;
        logic act;
    } t_dp_cmd;

endpackage

`default_nettype wire

### src/key_value_table.sv
// top level of the key value table
//
// Bounded key-value map of ENTRIES slots. A request (mode, key, value) is
// taken on a rising edge with start high and busy low; busy then stays high
// while the request is worked on. Insert stores a new key in the lowest free
// slot or updates the value of a key already present, search returns the
// stored value, delete removes the key and returns its old value.
// Every request gives one result on o_rsp, marked by o_valid for one cycle.
// The slot memories have one read port, so the scan reads one slot a cycle:
// the scan states are followed by a last read state and an update state, in
// which the result is registered. It is taken at the edge that ends its strobe
// cycle; busy is low again in that cycle, so the next request can be taken at
// that same edge.
// After reset a clearing pass marks every slot free, one slot a cycle; busy
// stays high during the pass and no request is taken meanwhile.
// The receiver cannot stall: each result must be taken in its strobe cycle.
// The entry count on the result is the count modulo 32.
`default_nettype none
`include "key_value_table_macros.svh"

module key_value_table
    import kvt_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    localparam int IDX_W  = $clog2(ENTRIES)
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    t_dp_cmd          cmd;
    logic [IDX_W-1:0] addr;

    // sequencing of clear, scan and update
    kvt_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .o_addr  (addr)
    );

    // slot storage and result generation
    kvt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_addr  (addr),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // checks on sequencing and result consistency
    `KVT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `KVT_ASSERT_NXT(a_single_strobe, o_valid, !o_valid)
    `KVT_ASSERT_IMP(a_result_when_idle, o_valid, !busy)
    `KVT_ASSERT_IMP(a_full_not_found, o_valid && o_rsp.table_full,
        !o_rsp.found && (o_rsp.value_out == '0))

endmodule

`default_nettype wire

### src/kvt_ctrl.sv
// controller of the key value table: clearing pass, slot scan and update sequencing
`default_nettype none

module kvt_ctrl
    import kvt_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    localparam int IDX_W  = $clog2(ENTRIES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    output t_dp_cmd               o_cmd,
    output logic [IDX_W-1:0]      o_addr
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_LAST  = 3'd3;
    localparam logic [2:0] S_ACT   = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic             accept;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // next state and slot counter
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                    n_addr  = '0;
                end
            end
            S_CLEAR: begin
                if (r_addr == LAST_IDX) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_SCAN: begin
                if (r_addr == LAST_IDX) begin
                    n_state = S_LAST;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_LAST: begin
                n_state = S_ACT;
            end
            S_ACT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_addr  = '0;
            end
        endcase
    end

    // state registers, reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    // datapath commands
    always_comb begin
        o_cmd.accept = accept;
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.act    = (r_state == S_ACT);
    end

    assign o_addr = r_addr;

endmodule

`default_nettype wire

### src/kvt_datapath.sv
// datapath of the key value table: slot memories, match and free search, result register
`default_nettype none

module kvt_datapath
    import kvt_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    localparam int IDX_W  = $clog2(ENTRIES),
    localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    input  wire logic [IDX_W-1:0] i_addr,
    input  wire t_req             i_req,
    output logic                  o_valid,
    output t_rsp                  o_rsp
);

    // slot memories
    logic [KEY_W-1:0] r_key_mem [ENTRIES];
    logic [VAL_W-1:0] r_val_mem [ENTRIES];
    logic             r_vld_mem [ENTRIES];

    // registered read data and its slot index
    logic [KEY_W-1:0] r_key_q;
    logic [VAL_W-1:0] r_val_q;
    logic             r_vld_q;
    logic             r_q_en;
    logic [IDX_W-1:0] r_q_idx;

    // captured request and scan outcome
    t_req             r_req;
    logic             r_hit, r_free;
    logic [IDX_W-1:0] r_hit_idx, r_free_idx;
    logic [VAL_W-1:0] r_hit_val;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_valid;
    t_rsp             r_rsp;

    logic             is_ins, is_srch, is_del;
    logic             ins_new, upd, del, refused;
    logic             match, free_slot;
    logic             vld_we, vld_wd, val_we;
    logic [IDX_W-1:0] vld_wa, val_wa;

    assign is_ins  = (r_req.mode == MODE_INSERT);
    assign is_srch = (r_req.mode == MODE_SEARCH);
    assign is_del  = (r_req.mode == MODE_DELETE);

    // compare stage on the registered read data
    assign match     = r_q_en && r_vld_q && (r_key_q == r_req.key);
    assign free_slot = r_q_en && !r_vld_q;

    // update decisions once the scan has finished
    assign ins_new = i_cmd.act && is_ins && !r_hit && r_free;
    assign upd     = i_cmd.act && is_ins && r_hit;
    assign del     = i_cmd.act && is_del && r_hit;
    assign refused = is_ins && !r_hit && !r_free;

    // write port selection
    assign vld_we = i_cmd.clear || ins_new || del;
    assign vld_wa = i_cmd.clear ? i_addr : (ins_new ? r_free_idx : r_hit_idx);
    assign vld_wd = ins_new;
    assign val_we = ins_new || upd;
    assign val_wa = ins_new ? r_free_idx : r_hit_idx;

    // entry count after this transaction
    always_comb begin
        n_count = r_count;
        if (ins_new) begin
            n_count = r_count + 1'b1;
        end else if (del && (r_count != '0)) begin
            n_count = r_count - 1'b1;
        end
    end

    // memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (vld_we) begin
            r_vld_mem[vld_wa] <= vld_wd;
        end
        if (ins_new) begin
            r_key_mem[r_free_idx] <= r_req.key;
        end
        if (val_we) begin
            r_val_mem[val_wa] <= r_req.value;
        end
        r_vld_q <= r_vld_mem[i_addr];
        r_key_q <= r_key_mem[i_addr];
        r_val_q <= r_val_mem[i_addr];
    end

    // control state of the scan and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_en  <= 1'b0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_q_en  <= i_cmd.scan;
            r_valid <= i_cmd.act;
            r_count <= n_count;
            if (i_cmd.accept) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else begin
                if (match) begin
                    r_hit <= 1'b1;
                end
                if (free_slot) begin
                    r_free <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_q_idx <= i_addr;
        if (i_cmd.accept) begin
            r_req <= i_req;
        end
        if (match && !r_hit) begin
            r_hit_idx <= r_q_idx;
            r_hit_val <= r_val_q;
        end
        if (free_slot && !r_free) begin
            r_free_idx <= r_q_idx;
        end
        if (i_cmd.act) begin
            r_rsp.found       <= (is_ins || is_srch || is_del) && r_hit;
            r_rsp.value_out   <= ((is_srch || is_del) && r_hit) ? r_hit_val : '0;
            r_rsp.entry_count <= COUNT_W'(n_count);
            r_rsp.table_full  <= refused;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

### dv/testbench.sv
// self-checking testbench for the key value table
`timescale 1ns / 1ps

module testbench;
    import kvt_pkg::*;

    // table size under test and run limits
    localparam int TABLE_SLOTS    = DEF_ENTRIES;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 2 * (TABLE_SLOTS + 3);
    localparam int POOL_SIZE      = 20;
    localparam int RANDOM_ROUNDS  = 8;
    localparam int ROUND_ITEMS    = 166;

    // unused operation code, no effect on the table
    localparam logic [1:0] MODE_NOP = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    // shadow copy of the table contents
    logic [KEY_W-1:0]   shadow_key  [TABLE_SLOTS];
    logic [VAL_W-1:0]   shadow_val  [TABLE_SLOTS];
    logic               shadow_used [TABLE_SLOTS];
    int unsigned        shadow_count = 0;

    // results still to come, oldest first
    t_rsp awaited_rsp[$];

    // stimulus shaping
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int unsigned      max_gap = 18;

    // tallies for the summary
    int unsigned error_count   = 0;
    int unsigned sent_count    = 0;
    int unsigned new_inserts   = 0;
    int unsigned updates       = 0;
    int unsigned refused       = 0;
    int unsigned lookup_hits   = 0;
    int unsigned lookup_misses = 0;
    int unsigned idle_cycles   = 0;

    key_value_table #(
        .ENTRIES (TABLE_SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // true if a valid slot of the shadow holds this key
    function automatic logic holds_key(input logic [KEY_W-1:0] k);
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (shadow_used[i] && shadow_key[i] == k)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one request to the shadow table and return its result
    function automatic t_rsp apply_request(input t_req req);
        t_rsp rsp;
        int   hit;
        int   free_slot;
        rsp       = '0;
        hit       = -1;
        free_slot = -1;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (shadow_used[i] && shadow_key[i] == req.key)
                hit = i;
            if (!shadow_used[i])
                free_slot = i;
        end
        case (req.mode)
            MODE_INSERT: begin
                if (hit >= 0) begin
                    rsp.found       = 1'b1;
                    shadow_val[hit] = req.value;
                    updates++;
                end else if (free_slot >= 0) begin
                    shadow_key[free_slot]  = req.key;
                    shadow_val[free_slot]  = req.value;
                    shadow_used[free_slot] = 1'b1;
                    shadow_count++;
                    new_inserts++;
                end else begin
                    rsp.table_full = 1'b1;
                    refused++;
                end
            end
            MODE_SEARCH, MODE_DELETE: begin
                if (hit >= 0) begin
                    rsp.found     = 1'b1;
                    rsp.value_out = shadow_val[hit];
                    lookup_hits++;
                    if (req.mode == MODE_DELETE) begin
                        shadow_used[hit] = 1'b0;
                        if (shadow_count > 0)
                            shadow_count--;
                    end
                end else begin
                    lookup_misses++;
                end
            end
            default: begin
                // unused code leaves the table alone
            end
        endcase
        rsp.entry_count = shadow_count[COUNT_W-1:0];
        return rsp;
    endfunction

    // send one request after a random pause and wait for the handshake
    task automatic issue_request(input logic [1:0] mode, input logic [KEY_W-1:0] k,
                                 input logic [VAL_W-1:0] v);
        int unsigned gap;
        t_req        req;
        gap       = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        req.mode  = mode;
        req.key   = k;
        req.value = v;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        awaited_rsp.push_back(apply_request(req));
        sent_count++;
    endtask

    // new pool of keys, extremes always among them
    task automatic refill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
    endtask

    // mostly pooled keys so that hits are common, sometimes any key
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 88)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // empty table, unused code and the extreme keys and values
    task automatic test_extreme_keys();
        issue_request(MODE_SEARCH, 32'h0000_0000, 32'hffff_ffff);
        issue_request(MODE_DELETE, 32'h8000_0000, 32'h0000_0000);
        issue_request(MODE_NOP,    32'h7fff_ffff, 32'h7fff_ffff);
        issue_request(MODE_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        issue_request(MODE_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        issue_request(MODE_INSERT, 32'h0000_0000, 32'hffff_ffff);
        issue_request(MODE_INSERT, 32'hffff_ffff, 32'h0000_0000);
        issue_request(MODE_SEARCH, 32'h8000_0000, 32'h0000_0000);
        issue_request(MODE_SEARCH, 32'h7fff_ffff, 32'hffff_ffff);
        issue_request(MODE_INSERT, 32'h0000_0000, 32'h5a5a_a5a5);
        issue_request(MODE_DELETE, 32'hffff_ffff, 32'h1234_5678);
        issue_request(MODE_SEARCH, 32'hffff_ffff, 32'h0000_0000);
        issue_request(MODE_NOP,    32'h0000_0000, 32'h0000_0000);
    endtask

    // fill to the top, refuse a new key, update while full, reuse a freed slot
    task automatic test_overflow();
        logic [KEY_W-1:0] k;
        while (shadow_count < TABLE_SLOTS) begin
            k = $urandom;
            if (!holds_key(k))
                issue_request(MODE_INSERT, k, $urandom);
        end
        do
            k = $urandom;
        while (holds_key(k));
        issue_request(MODE_INSERT, k, $urandom);
        issue_request(MODE_INSERT, shadow_key[5], $urandom);
        issue_request(MODE_SEARCH, shadow_key[5], $urandom);
        issue_request(MODE_DELETE, shadow_key[3], $urandom);
        issue_request(MODE_INSERT, k, $urandom);
        issue_request(MODE_SEARCH, k, $urandom);
    endtask

    // random traffic, rounds alternate between filling and draining
    task automatic test_random_traffic();
        int unsigned insert_pct;
        int unsigned roll;
        logic [1:0]  mode;
        for (int r = 0; r < RANDOM_ROUNDS; r++) begin
            refill_pool();
            insert_pct = (r % 2 == 0) ? $urandom_range(50, 70) : $urandom_range(20, 40);
            max_gap    = (r % 3 == 2) ? 0 : 18;
            for (int n = 0; n < ROUND_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 6)
                    mode = MODE_NOP;
                else if (roll < 6 + insert_pct)
                    mode = MODE_INSERT;
                else if (roll < 6 + insert_pct + (94 - insert_pct) / 2)
                    mode = MODE_SEARCH;
                else
                    mode = MODE_DELETE;
                issue_request(mode, pick_key(), $urandom);
            end
        end
        max_gap = 18;
    endtask

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (awaited_rsp.size() == 0) begin
                $error("result with nothing expected: %h", o_rsp);
                error_count++;
            end else begin
                want = awaited_rsp.pop_front();
                if (o_rsp.found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, o_rsp.found);
                    error_count++;
                end
                if (o_rsp.value_out !== want.value_out) begin
                    $error("value_out: expected %h, actual %h",
                           want.value_out, o_rsp.value_out);
                    error_count++;
                end
                if (o_rsp.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, o_rsp.entry_count);
                    error_count++;
                end
                if (o_rsp.table_full !== want.table_full) begin
                    $error("table_full: expected %0d, actual %0d",
                           want.table_full, o_rsp.table_full);
                    error_count++;
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // reset, test sequence, drain and verdict
    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            shadow_key[i]  = '0;
            shadow_val[i]  = '0;
            shadow_used[i] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_keys();
        test_overflow();
        test_random_traffic();

        start <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d new keys stored, %0d updates, %0d refused on a full table",
                 sent_count, new_inserts, updates, refused);
        $display("%0d search or delete hits, %0d misses, %0d field mismatches",
                 lookup_hits, lookup_misses, error_count);
        if (error_count == 0 && awaited_rsp.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
